@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Condition that must also hold while reset is asserted
`define ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/fmul_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmul_pkg
// Types and constants shared by the binary32 multiplier pipeline.
// ----------------------------------------------------------------------------
package fmul_pkg;

    localparam int FracW = 23;
    localparam int ExpW  = 8;
    localparam int SigW  = FracW + 1;
    localparam int ProdW = 2 * SigW;
    localparam int InW   = 2 * (1 + ExpW + FracW);
    localparam int OutW  = 1 + ExpW + FracW + 2;
    localparam int OutTdataW = ((OutW + 7) / 8) * 8;
    localparam logic [9:0] ExpBias  = 10'd127;
    localparam logic [9:0] ExpMaxOk = 10'd254;

    // Control fields decoded from the operands
    typedef struct packed {
        logic             zero;      // result is a passed-through zero
        logic             zero_sign;
        logic             sign;
        logic [9:0]       exp;       // signed biased sum, two's complement
    } fmul_ctl_t;

    typedef struct packed {
        logic             sign;
        logic [ExpW-1:0]  exponent;
        logic [FracW-1:0] fraction;
        logic             underflow;
        logic             overflow;
    } fmul_result_t;

endpackage

@@ hw/rtl/fmul_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmul_mult
// Stage 1 and 2: operand decode and 24x24 significand multiply.
// ----------------------------------------------------------------------------
module fmul_mult (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [fmul_pkg::InW-1:0]      operands,
    output logic                          out_valid,
    output fmul_pkg::fmul_ctl_t           ctl,
    output logic [fmul_pkg::ProdW-1:0]    prod
);
    import fmul_pkg::*;

    logic             as, bs;
    logic [ExpW-1:0]  ae, be;
    logic [FracW-1:0] af, bf;
    fmul_ctl_t        ctl_next, ctl1_reg, ctl2_reg;
    logic [SigW-1:0]  siga_reg, sigb_reg;
    logic [ProdW-1:0] prod_reg;
    logic             v1_reg, v2_reg;

    assign {bf, be, bs, af, ae, as} = operands;

    always_comb
    begin
        ctl_next.zero      = ((ae == '0) && (af == '0)) || ((be == '0) && (bf == '0));
        ctl_next.zero_sign = ((ae == '0) && (af == '0)) ? as : bs;
        ctl_next.sign      = as ^ bs;
        ctl_next.exp       = {2'b00, ae} + {2'b00, be} - ExpBias;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg <= ctl_next;
            siga_reg <= {1'b1, af};
            sigb_reg <= {1'b1, bf};
            ctl2_reg <= ctl1_reg;
            prod_reg <= siga_reg * sigb_reg;
        end
    end

    assign out_valid = v2_reg;
    assign ctl       = ctl2_reg;
    assign prod      = prod_reg;
endmodule

@@ hw/rtl/fmul_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmul_round
// Stage 3 and 4: normalize and round, then range check and pack.
// ----------------------------------------------------------------------------
module fmul_round (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  fmul_pkg::fmul_ctl_t           ctl,
    input  logic [fmul_pkg::ProdW-1:0]    prod,
    output logic                          out_valid,
    output fmul_pkg::fmul_result_t        result
);
    import fmul_pkg::*;

    logic [SigW:0]    sig;
    logic [9:0]       exp_n;
    logic [SigW:0]    sig_reg;
    logic [9:0]       exp_reg;
    fmul_ctl_t        ctl3_reg;
    logic             v3_reg, v4_reg;
    fmul_result_t     res_next, res_reg;
    logic [FracW-1:0] frac;
    logic [9:0]       exp_f;

    // round half up at the bit below the kept 24
    always_comb
    begin
        if (prod[ProdW-1])
        begin
            sig   = (SigW+1)'(({1'b0, prod} + (ProdW+1)'(1 << 23)) >> 24);
            exp_n = ctl.exp + 10'd1;
        end
        else
        begin
            sig   = (SigW+1)'(({1'b0, prod} + (ProdW+1)'(1 << 22)) >> 23);
            exp_n = ctl.exp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        if (sig_reg[SigW])
        begin
            frac  = sig_reg[FracW:1];
            exp_f = exp_reg + 10'd1;
        end
        else
        begin
            frac  = sig_reg[FracW-1:0];
            exp_f = exp_reg;
        end
        res_next = '0;
        if (ctl3_reg.zero)
            res_next.sign = ctl3_reg.zero_sign;
        else
        begin
            res_next.sign = ctl3_reg.sign;
            if (exp_f[9] || (exp_f == '0))
                res_next.underflow = 1'b1;
            else if (exp_f > ExpMaxOk)
                res_next.overflow = 1'b1;
            else
            begin
                res_next.exponent = exp_f[ExpW-1:0];
                res_next.fraction = frac;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sig_reg  <= sig;
            exp_reg  <= exp_n;
            ctl3_reg <= ctl;
            res_reg  <= res_next;
        end
    end

    assign out_valid = v4_reg;
    assign result    = res_reg;
endmodule

@@ hw/rtl/float32_multiplier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_multiplier
// Pipelined IEEE 754 binary32 multiply, round to nearest ties up.
// ----------------------------------------------------------------------------
// Channel  Dir  Content
// s_axis   in   operands a and b
// m_axis   out  product fields and range flags
//
// Four register stages: decode, 24x24 multiply, round, range check and pack.
// One transaction per cycle while m_axis_tready is high.
// A stall freezes the whole pipeline; s_axis_tready is low only while the
// last stage holds an untaken result. Reset clears only the valid bits.
module float32_multiplier (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // a_sign, a_exponent, a_fraction, b_sign, b_exponent, b_fraction
    input  logic [fmul_pkg::InW-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // product_sign, product_exponent, product_fraction, underflow, overflow, pad
    output logic [fmul_pkg::OutTdataW-1:0] m_axis_tdata
);
    import fmul_pkg::*;

    logic         en, v2;
    fmul_ctl_t    ctl;
    logic [ProdW-1:0] prod;
    fmul_result_t res;

    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    fmul_mult u_mult (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_axis_tvalid),
        .operands(s_axis_tdata), .out_valid(v2), .ctl(ctl), .prod(prod)
    );

    fmul_round u_round (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2), .ctl(ctl),
        .prod(prod), .out_valid(m_axis_tvalid), .result(res)
    );

    assign m_axis_tdata = {(OutTdataW-OutW)'(0), res.overflow, res.underflow,
                           res.fraction, res.exponent, res.sign};
endmodule

@@ hw/rtl/fmul_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmul_checker
// Port-level checks for the binary32 multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmul_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [fmul_pkg::OutTdataW-1:0] m_axis_tdata
);
    import fmul_pkg::*;

    `ASSERT_IMPL(a_flags_excl, clk, rst_n, !(m_axis_tvalid && m_axis_tdata[32] && m_axis_tdata[33]))
    `ASSERT_IMPL(a_err_zero, clk, rst_n, !(m_axis_tvalid && (m_axis_tdata[32] || m_axis_tdata[33])) || (m_axis_tdata[31:1] == '0))
    `ASSERT_IMPL(a_stall_hold, clk, rst_n, !($past(m_axis_tvalid && !m_axis_tready)) || (m_axis_tvalid && $stable(m_axis_tdata)))
    `ASSERT_IMPL(a_ready, clk, rst_n, s_axis_tready == (m_axis_tready || !m_axis_tvalid))
    `ASSERT_ALWAYS(a_rst_idle, clk, rst_n || !m_axis_tvalid)
endmodule

bind float32_multiplier fmul_checker u_fmul_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
